/* sv/ecp_pkg.sv */
// shared constants, types and microprogram for the easing curve progress unit
`default_nettype none

package ecp_pkg;

	// fixed point format of the easing path
	localparam int FRAC_BITS = 16;
	localparam int PROG_W    = FRAC_BITS + 1;
	localparam int VAL_W     = PROG_W + 1;
	localparam int CNT_W     = $clog2(FRAC_BITS);

	localparam logic [VAL_W-1:0]  ONE_V   = VAL_W'(1) << FRAC_BITS;
	localparam logic [VAL_W-1:0]  THREE_V = ONE_V + (ONE_V << 1);
	localparam logic [PROG_W-1:0] ONE_P   = ONE_V[PROG_W-1:0];

	// field and register widths
	localparam int REQ_W      = 2;
	localparam int TIME_W     = 32;
	localparam int DUR_MS_W   = 20;
	localparam int DUR_US_W   = 30;
	localparam int MODE_W     = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DUR_MS_W;

	localparam logic [DUR_MS_W-1:0] DUR_MS_RESET = DUR_MS_W'(1000);
	localparam logic [DUR_US_W-1:0] US_PER_MS    = DUR_US_W'(1000);

	// request codes
	localparam logic [REQ_W-1:0] REQ_UPDATE  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RESTART = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STOP    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE    = 1'b1;

	// curve codes
	localparam logic [MODE_W-1:0] CURVE_LINEAR      = 4'd0;
	localparam logic [MODE_W-1:0] CURVE_QUAD_IN     = 4'd1;
	localparam logic [MODE_W-1:0] CURVE_QUAD_OUT    = 4'd2;
	localparam logic [MODE_W-1:0] CURVE_QUAD_INOUT  = 4'd3;
	localparam logic [MODE_W-1:0] CURVE_CUBIC_IN    = 4'd4;
	localparam logic [MODE_W-1:0] CURVE_CUBIC_OUT   = 4'd5;
	localparam logic [MODE_W-1:0] CURVE_CUBIC_INOUT = 4'd6;
	localparam logic [MODE_W-1:0] CURVE_QUINT_IN    = 4'd7;
	localparam logic [MODE_W-1:0] CURVE_QUINT_OUT   = 4'd8;
	localparam logic [MODE_W-1:0] CURVE_QUINT_INOUT = 4'd9;
	localparam logic [MODE_W-1:0] CURVE_SMOOTH     = 4'd10;

	// micro-operations
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_IDLE  = 3'd0;
	localparam logic [OP_W-1:0] OP_CHECK = 3'd1;
	localparam logic [OP_W-1:0] OP_DIV   = 3'd2;
	localparam logic [OP_W-1:0] OP_SETUP = 3'd3;
	localparam logic [OP_W-1:0] OP_MUL   = 3'd4;
	localparam logic [OP_W-1:0] OP_POST  = 3'd5;

	// jump conditions
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] COND_ALWAYS  = 3'd0;
	localparam logic [COND_W-1:0] COND_IDLE    = 3'd1;
	localparam logic [COND_W-1:0] COND_TIMEOUT = 3'd2;
	localparam logic [COND_W-1:0] COND_CNT_NZ  = 3'd3;
	localparam logic [COND_W-1:0] COND_NOMUL   = 3'd4;

	// program addresses
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] ST_WAIT  = 3'd0;
	localparam logic [PC_W-1:0] ST_CHECK = 3'd1;
	localparam logic [PC_W-1:0] ST_DIV   = 3'd2;
	localparam logic [PC_W-1:0] ST_SETUP = 3'd3;
	localparam logic [PC_W-1:0] ST_MUL   = 3'd4;
	localparam logic [PC_W-1:0] ST_POST  = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
	} uword_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            load;
	} dp_ctl_t;

	typedef struct packed {
		logic timeout;
		logic cnt_nz;
		logic nomul;
	} dp_stat_t;

	// control store: jump to target when the condition holds, else fall through
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			ST_WAIT:  w = '{op: OP_IDLE,  cond: COND_IDLE,    target: ST_WAIT};
			ST_CHECK: w = '{op: OP_CHECK, cond: COND_TIMEOUT, target: ST_WAIT};
			ST_DIV:   w = '{op: OP_DIV,   cond: COND_CNT_NZ,  target: ST_DIV};
			ST_SETUP: w = '{op: OP_SETUP, cond: COND_NOMUL,   target: ST_POST};
			ST_MUL:   w = '{op: OP_MUL,   cond: COND_CNT_NZ,  target: ST_MUL};
			ST_POST:  w = '{op: OP_POST,  cond: COND_ALWAYS,  target: ST_WAIT};
			default:  w = '{op: OP_IDLE,  cond: COND_ALWAYS,  target: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* sv/ecp_if.sv */
// request and result stream interfaces of the easing curve progress unit
`default_nettype none

interface ecp_req_if;
	import ecp_pkg::*;
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [TIME_W-1:0] now_us;

	modport source (output valid, output req_type, output now_us, input ready);
	modport sink (input valid, input req_type, input now_us, output ready);
endinterface

interface ecp_res_if;
	import ecp_pkg::*;
	logic              valid;
	logic              ready;
	logic              value_valid;
	logic [PROG_W-1:0] progress;
	logic              done_res;

	modport source (output valid, output value_valid, output progress, output done_res,
		input ready);
	modport sink (input valid, input value_valid, input progress, input done_res,
		output ready);
endinterface

`default_nettype wire

/* sv/ecp_datapath.sv */
// datapath: elapsed time, radix-2 divider, shared multiplier and curve post-processing
`default_nettype none

module ecp_datapath (
	input  logic                           clk,
	input  ecp_pkg::dp_ctl_t               ctl,
	input  logic [ecp_pkg::TIME_W-1:0]     now_us,
	input  logic [ecp_pkg::TIME_W-1:0]     start_time,
	input  logic [ecp_pkg::DUR_MS_W-1:0]   duration_ms,
	input  logic [ecp_pkg::MODE_W-1:0]     curve_mode,
	output ecp_pkg::dp_stat_t              stat,
	output logic [ecp_pkg::PROG_W-1:0]     result
);
	import ecp_pkg::*;

	localparam int POST_W = 3;
	localparam logic [POST_W-1:0] POST_PASS     = 3'd0;
	localparam logic [POST_W-1:0] POST_HALF     = 3'd1;
	localparam logic [POST_W-1:0] POST_ONE_MIN  = 3'd2;
	localparam logic [POST_W-1:0] POST_ONE_HALF = 3'd3;
	localparam logic [POST_W-1:0] POST_TWO_HALF = 3'd4;

	logic [TIME_W-1:0]   elapsed_q;
	logic [DUR_US_W-1:0] dur_q;
	logic [DUR_US_W-1:0] rem_q;
	logic [PROG_W-1:0]   quo_q;
	logic [VAL_W-1:0]    acc_q;
	logic [VAL_W-1:0]    opnd_q;
	logic [VAL_W-1:0]    sec_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [POST_W-1:0]   post_q;

	logic [DUR_US_W-1:0] dur_us;
	logic                eq;
	logic [DUR_US_W:0]   rem_sh;
	logic [DUR_US_W:0]   rem_sub;
	logic                ge;

	logic [VAL_W-1:0]    x;
	logic [VAL_W-1:0]    t;
	logic                lo;
	logic [VAL_W-1:0]    su_base;
	logic [VAL_W-1:0]    su_opnd;
	logic [VAL_W-1:0]    su_sec;
	logic [2:0]          su_nmul;
	logic [POST_W-1:0]   su_post;

	logic [2*VAL_W-1:0]  prod;
	logic [VAL_W:0]      post_v;

	assign dur_us  = DUR_US_W'(duration_ms) * US_PER_MS;
	assign eq      = elapsed_q == TIME_W'(dur_q);
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, dur_q};
	assign ge      = rem_sh >= {1'b0, dur_q};
	assign prod    = acc_q * opnd_q;

	assign stat.timeout = (dur_q == '0) || (elapsed_q > TIME_W'(dur_q));
	assign stat.cnt_nz  = cnt_q != '0;
	assign stat.nomul   = su_nmul == 3'd0;

	// curve setup: base value, multiplier operands, multiply count, final fix-up
	assign x  = VAL_W'(quo_q);
	assign t  = {quo_q, 1'b0};
	assign lo = t < ONE_V;

	always_comb begin
		su_base = x;
		su_opnd = x;
		su_sec  = x;
		su_nmul = 3'd0;
		su_post = POST_PASS;
		unique case (curve_mode)
			CURVE_QUAD_IN: begin
				su_nmul = 3'd1;
			end
			CURVE_QUAD_OUT: begin
				su_opnd = (ONE_V << 1) - x;
				su_nmul = 3'd1;
			end
			CURVE_QUAD_INOUT: begin
				su_nmul = 3'd1;
				if (lo) begin
					su_base = t;
					su_opnd = t;
					su_post = POST_HALF;
				end else begin
					su_base = t - ONE_V;
					su_opnd = THREE_V - t;
					su_post = POST_ONE_HALF;
				end
				su_sec = su_opnd;
			end
			CURVE_CUBIC_IN, CURVE_QUINT_IN: begin
				su_nmul = (curve_mode == CURVE_CUBIC_IN) ? 3'd2 : 3'd4;
			end
			CURVE_CUBIC_OUT, CURVE_QUINT_OUT: begin
				su_base = ONE_V - x;
				su_opnd = su_base;
				su_sec  = su_base;
				su_nmul = (curve_mode == CURVE_CUBIC_OUT) ? 3'd2 : 3'd4;
				su_post = POST_ONE_MIN;
			end
			CURVE_CUBIC_INOUT, CURVE_QUINT_INOUT: begin
				su_nmul = (curve_mode == CURVE_CUBIC_INOUT) ? 3'd2 : 3'd4;
				if (lo) begin
					su_base = t;
					su_post = POST_HALF;
				end else begin
					su_base = (ONE_V << 1) - t;
					su_post = POST_TWO_HALF;
				end
				su_opnd = su_base;
				su_sec  = su_base;
			end
			CURVE_SMOOTH: begin
				su_sec  = THREE_V - t;
				su_nmul = 3'd2;
			end
			default: begin
				su_nmul = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_IDLE: begin
				if (ctl.load) begin
					elapsed_q <= now_us - start_time;
					dur_q     <= dur_us;
				end
			end
			OP_CHECK: begin
				rem_q <= eq ? '0 : elapsed_q[DUR_US_W-1:0];
				quo_q <= PROG_W'(eq);
				cnt_q <= CNT_W'(FRAC_BITS - 1);
			end
			OP_DIV: begin
				rem_q <= ge ? rem_sub[DUR_US_W-1:0] : rem_sh[DUR_US_W-1:0];
				quo_q <= {quo_q[PROG_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			OP_SETUP: begin
				acc_q  <= su_base;
				opnd_q <= su_opnd;
				sec_q  <= su_sec;
				cnt_q  <= CNT_W'(su_nmul - 3'd1);
				post_q <= su_post;
			end
			OP_MUL: begin
				acc_q  <= prod[FRAC_BITS +: VAL_W];
				opnd_q <= sec_q;
				cnt_q  <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (post_q)
			POST_HALF:     post_v = {2'b0, acc_q[VAL_W-1:1]};
			POST_ONE_MIN:  post_v = {1'b0, ONE_V - acc_q};
			POST_ONE_HALF: post_v = ({1'b0, ONE_V} + {1'b0, acc_q}) >> 1;
			POST_TWO_HALF: post_v = ({1'b0, ONE_V << 1} - {1'b0, acc_q}) >> 1;
			default:       post_v = {1'b0, acc_q};
		endcase
	end

	assign result = (post_v > {1'b0, ONE_V}) ? ONE_P : post_v[PROG_W-1:0];

endmodule

`default_nettype wire

/* sv/easing_curve_progress_unit.sv */
// top level of the easing curve progress unit: microsequencer, state and result register
//
// usage
//   req channel: one transfer per request (req_type: update, restart, stop; now_us
//   timestamp). res channel: exactly one transfer per request with value_valid,
//   progress (Q1.16, 65536 = 1.0) and done_res.
//   configuration: cfg_we with cfg_idx selects duration_ms (index 0) or curve_mode
//   (index 1); write only while no request is in flight.
// sequencing
//   restart, stop, and update while done: result registered at the accept edge,
//   a new request can follow in the next cycle if the result is taken in that cycle.
//   update that times out: answered from the compare step. other updates walk a
//   microprogram: one compare step, 16 divider steps (one quotient bit per step),
//   one setup step, 0 to 4 steps of the single shared 18x18 multiplier and one
//   post step, during which no request is taken.
// reset
//   duration 1000 ms, linear curve, start time 0, not done, result register empty.
// stall
//   the result register holds until taken; a request is accepted only while it is
//   empty or being drained in the same cycle.
`default_nettype none

module easing_curve_progress_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	ecp_req_if.sink                            req,
	ecp_res_if.source                          res,
	input  logic                               cfg_we,
	input  logic [ecp_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [ecp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import ecp_pkg::*;

	// sequencer and architectural state
	logic [PC_W-1:0]     pc_q;
	logic [DUR_MS_W-1:0] dur_ms_q;
	logic [MODE_W-1:0]   mode_q;
	logic [TIME_W-1:0]   start_q;
	logic                fin_q;

	// result register
	logic                out_v_q;
	logic                out_vv_q;
	logic [PROG_W-1:0]   out_prog_q;
	logic                out_done_q;

	uword_t              uw;
	dp_ctl_t             ctl;
	dp_stat_t            stat;
	logic [PROG_W-1:0]   dp_result;

	logic                rdy;
	logic                fire;
	logic                go;
	logic                jump;
	logic                tmo_now;

	logic                ld;
	logic                ld_vv;
	logic [PROG_W-1:0]   ld_prog;
	logic                ld_done;

	assign uw = ucode(pc_q);

	// take a request only at the wait step with room in the result register
	assign rdy  = (pc_q == ST_WAIT) && (!out_v_q || res.ready);
	assign fire = req.valid && rdy;
	// an update on a running animation is the only request that needs the datapath
	assign go   = fire && (req.req_type == REQ_UPDATE) && !fin_q;

	assign tmo_now = (uw.op == OP_CHECK) && stat.timeout;

	always_comb begin
		case (uw.cond)
			COND_ALWAYS:  jump = 1'b1;
			COND_IDLE:    jump = !go;
			COND_TIMEOUT: jump = stat.timeout;
			COND_CNT_NZ:  jump = stat.cnt_nz;
			COND_NOMUL:   jump = stat.nomul;
			default:      jump = 1'b0;
		endcase
	end

	assign ctl.op   = uw.op;
	assign ctl.load = go;

	ecp_datapath u_dp (
		.clk         (clk),
		.ctl         (ctl),
		.now_us      (req.now_us),
		.start_time  (start_q),
		.duration_ms (dur_ms_q),
		.curve_mode  (mode_q),
		.stat        (stat),
		.result      (dp_result)
	);

	// result register load: immediate answers, timeouts and finished curves
	always_comb begin
		ld      = 1'b0;
		ld_vv   = 1'b0;
		ld_prog = '0;
		ld_done = fin_q;
		if (fire && !go) begin
			ld = 1'b1;
			if (req.req_type == REQ_RESTART) begin
				ld_done = 1'b0;
			end else if (req.req_type == REQ_STOP) begin
				ld_done = 1'b1;
			end
		end else if (tmo_now) begin
			ld      = 1'b1;
			ld_vv   = 1'b1;
			ld_prog = ONE_P;
			ld_done = 1'b1;
		end else if (uw.op == OP_POST) begin
			ld      = 1'b1;
			ld_vv   = 1'b1;
			ld_prog = dp_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= ST_WAIT;
			dur_ms_q <= DUR_MS_RESET;
			mode_q   <= CURVE_LINEAR;
			start_q  <= '0;
			fin_q    <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			pc_q <= jump ? uw.target : pc_q + 1'b1;

			if (cfg_we) begin
				if (cfg_idx == CFG_DURATION) begin
					dur_ms_q <= cfg_wdata[DUR_MS_W-1:0];
				end else if (cfg_idx == CFG_CURVE) begin
					mode_q <= cfg_wdata[MODE_W-1:0];
				end
			end

			// restart latches the start time, stop and timeout mark the animation done
			if (fire && (req.req_type == REQ_RESTART)) begin
				start_q <= req.now_us;
				fin_q   <= 1'b0;
			end else if ((fire && (req.req_type == REQ_STOP)) || tmo_now) begin
				fin_q <= 1'b1;
			end

			if (ld) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_vv_q   <= ld_vv;
			out_prog_q <= ld_prog;
			out_done_q <= ld_done;
		end
	end

	assign req.ready       = rdy;
	assign res.valid       = out_v_q;
	assign res.value_valid = out_vv_q;
	assign res.progress    = out_prog_q;
	assign res.done_res    = out_done_q;

endmodule

`default_nettype wire

/* sv/ecp_checker.sv */
// port-level checks of the easing curve progress unit and their binding
`default_nettype none

module ecp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic [ecp_pkg::REQ_W-1:0]      req_type,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic                           res_value_valid,
	input logic [ecp_pkg::PROG_W-1:0]     res_progress,
	input logic                           res_done_res
);
	import ecp_pkg::*;

	// a pending result is never withdrawn
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// no value means zero progress
	a_no_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_value_valid |-> res_progress == '0)
		else $error("progress nonzero without a value");

	// eased progress stays within 0..1.0
	a_prog_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_progress <= ONE_P)
		else $error("progress above one");

	// a stop is answered in the next cycle with the done flag set
	a_stop_done: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == REQ_STOP) |=> res_valid && res_done_res)
		else $error("stop not answered with done");

endmodule

bind easing_curve_progress_unit ecp_checker u_ecp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_type        (req.req_type),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_value_valid (res.value_valid),
	.res_progress    (res.progress),
	.res_done_res    (res.done_res)
);

`default_nettype wire
